FILE: src/mqc_pkg.sv
// ----------------------------------------------------------------------------
// mqc_pkg: shared types and constants
// Widths, codes and the quadrature transition table of the
// multi-channel quadrature counter.
// ----------------------------------------------------------------------------
`default_nettype none

package mqc_pkg;

    localparam int MAX_ENCODERS = 8;
    localparam int PORT_COUNT   = 3;
    localparam int COUNT_BITS   = 32;

    localparam int PORT_W     = 2;
    localparam int SAMPLE_W   = 8;
    localparam int PIN_W      = 3;
    localparam int MODE_W     = 2;
    localparam int ENC_IDX_W  = 3;
    localparam int POS_W      = 32;
    localparam int DIR_W      = 2;
    localparam int PORT_SEL_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;

    localparam int ENC_COUNT_W  = 4;
    localparam int ENC_PORTS_W  = 16;
    localparam int ENC_PINS_W   = 24;
    localparam int ENC_MODES_W  = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;
    localparam int QUEUE_CNT_W = 2;

    localparam logic signed [DIR_W-1:0] DIR_NONE = 2'sb00;
    localparam logic signed [DIR_W-1:0] DIR_FWD  = 2'sb01;
    localparam logic signed [DIR_W-1:0] DIR_BWD  = 2'sb11;

    typedef enum logic [MODE_W-1:0] {
        MODE_1X     = 2'd0,
        MODE_2X     = 2'd1,
        MODE_4X     = 2'd2,
        MODE_1X_ALT = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENCODER_COUNT = 3'd0,
        REG_ENCODER_PORTS = 3'd1,
        REG_ENCODER_PIN_A = 3'd2,
        REG_ENCODER_PIN_B = 3'd3,
        REG_ENCODER_MODES = 3'd4
    } reg_index_t;

    typedef enum logic {
        BACK_IDLE,
        BACK_WALK
    } back_state_t;

    typedef struct packed {
        logic [ENC_COUNT_W-1:0] encoder_count;
        logic [ENC_PORTS_W-1:0] encoder_ports;
        logic [ENC_PINS_W-1:0]  encoder_pin_a;
        logic [ENC_PINS_W-1:0]  encoder_pin_b;
        logic [ENC_MODES_W-1:0] encoder_modes;
    } cfg_t;

    typedef struct packed {
        logic [PORT_W-1:0]   port;
        logic [SAMPLE_W-1:0] sample;
        logic [SAMPLE_W-1:0] diff;
    } sample_item_t;

    // 4x decode, key is {old A, old B, new A, new B}
    function automatic logic signed [DIR_W-1:0] step_lookup(input logic [3:0] key);
        logic signed [DIR_W-1:0] step;
        unique case (key)
            4'd1, 4'd7, 4'd8, 4'd14:  step = DIR_BWD;
            4'd2, 4'd4, 4'd11, 4'd13: step = DIR_FWD;
            default:                  step = DIR_NONE;
        endcase
        return step;
    endfunction

endpackage

`default_nettype wire

FILE: src/mqc_in_if.sv
// ----------------------------------------------------------------------------
// mqc_in_if: port sample channel
// Valid/ready channel carrying one port index and its new level sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqc_in_if
    import mqc_pkg::*;
;
    logic                valid;
    logic                ready;
    logic [PORT_W-1:0]   port_index;
    logic [SAMPLE_W-1:0] port_value;

    modport source (output valid, output port_index, output port_value, input ready);
    modport sink   (input valid, input port_index, input port_value, output ready);
endinterface

`default_nettype wire

FILE: src/mqc_out_if.sv
// ----------------------------------------------------------------------------
// mqc_out_if: encoder result channel
// Valid/ready channel carrying one encoder's count and direction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqc_out_if
    import mqc_pkg::*;
;
    logic                        valid;
    logic                        ready;
    logic [ENC_IDX_W-1:0]        encoder_index;
    logic signed [POS_W-1:0]     position_count;
    logic signed [DIR_W-1:0]     last_direction;
    logic                        final_result;

    modport source (output valid, output encoder_index, output position_count,
                    output last_direction, output final_result, input ready);
    modport sink   (input valid, input encoder_index, input position_count,
                    input last_direction, input final_result, output ready);
endinterface

`default_nettype wire

FILE: src/mqc_cfg_if.sv
// ----------------------------------------------------------------------------
// mqc_cfg_if: configuration write channel
// Valid/ready channel carrying a register index and write data.
// ----------------------------------------------------------------------------
`default_nettype none

interface mqc_cfg_if
    import mqc_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: src/multi_quadrature_counter.sv
// ----------------------------------------------------------------------------
// multi_quadrature_counter: multi-channel quadrature counter
// Configuration registers, sample front end, queue and encoder walker.
// ----------------------------------------------------------------------------
// Up to eight quadrature encoders share three 8-bit input ports. Each port
// sample is accepted into a two-entry queue; unchanged samples and samples
// of an absent port are dropped before it. The encoder walker then pops a
// sample and steps through the encoder indices from zero up to the highest
// encoder the sample touches (a sample that touches no encoder is popped
// and dropped), stalling while a result waits and the result channel holds
// ready low. One transaction per touched encoder comes out, in encoder
// order, the last one flagged by final_result. Configuration writes are
// always accepted. Configuration writes should be issued only while no
// results are pending.
`default_nettype none

module multi_quadrature_counter
    import mqc_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mqc_in_if.sink     in,
    mqc_out_if.source  out,
    mqc_cfg_if.sink    cfg
);

    cfg_t         cfg_reg;
    logic         q_full;
    logic         q_push;
    sample_item_t q_push_item;
    logic         q_pop;
    sample_item_t q_pop_item;
    logic         q_empty;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_ENCODER_COUNT: cfg_reg.encoder_count <= cfg.data[ENC_COUNT_W-1:0];
                REG_ENCODER_PORTS: cfg_reg.encoder_ports <= cfg.data[ENC_PORTS_W-1:0];
                REG_ENCODER_PIN_A: cfg_reg.encoder_pin_a <= cfg.data[ENC_PINS_W-1:0];
                REG_ENCODER_PIN_B: cfg_reg.encoder_pin_b <= cfg.data[ENC_PINS_W-1:0];
                REG_ENCODER_MODES: cfg_reg.encoder_modes <= cfg.data[ENC_MODES_W-1:0];
                default:           cfg_reg <= cfg_reg;
            endcase
        end
    end

    mqc_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .in     (in),
        .q_full (q_full),
        .q_push (q_push),
        .q_item (q_push_item)
    );

    mqc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_item  (q_pop_item),
        .empty     (q_empty)
    );

    mqc_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .q_empty (q_empty),
        .q_item  (q_pop_item),
        .q_pop   (q_pop),
        .out     (out)
    );

endmodule

`default_nettype wire

FILE: src/mqc_queue.sv
// ----------------------------------------------------------------------------
// mqc_queue: sample queue
// Short FIFO of changed port samples between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mqc_queue
    import mqc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    input  wire sample_item_t push_item,
    output logic              full,
    input  wire logic         pop,
    output sample_item_t      pop_item,
    output logic              empty
);

    sample_item_t             slot_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0]   fill_reg;
    logic [QUEUE_CNT_W-1:0]   fill_next;
    logic                     do_push;
    logic                     do_pop;

    assign full     = (fill_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign empty    = (fill_reg == '0);
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_item = slot_reg[rd_ptr_reg];

    always_comb
    begin
        fill_next = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

FILE: src/mqc_front.sv
// ----------------------------------------------------------------------------
// mqc_front: sample front end
// Accepts port samples, drops unchanged or out-of-range ones, keeps the
// previous sample of each port and queues changed samples with their diff.
// ----------------------------------------------------------------------------
`default_nettype none

module mqc_front
    import mqc_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    mqc_in_if.sink       in,
    input  wire logic    q_full,
    output logic         q_push,
    output sample_item_t q_item
);

    logic [SAMPLE_W-1:0]   prev_sample_reg [PORT_COUNT];
    logic [PORT_SEL_W-1:0] port_sel;
    logic                  port_ok;
    logic [SAMPLE_W-1:0]   diff;
    logic                  accept;

    assign in.ready = !q_full;
    assign accept   = in.valid && in.ready;
    assign port_sel = in.port_index[PORT_SEL_W-1:0];
    assign port_ok  = (32'(in.port_index) < PORT_COUNT);
    assign diff     = port_ok ? (in.port_value ^ prev_sample_reg[port_sel]) : '0;

    // Forward only samples that actually changed a valid port
    assign q_push        = accept && port_ok && (diff != '0);
    assign q_item.port   = in.port_index;
    assign q_item.sample = in.port_value;
    assign q_item.diff   = diff;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PORT_COUNT; p++)
            begin
                prev_sample_reg[p] <= '0;
            end
        end
        else if (q_push)
        begin
            prev_sample_reg[port_sel] <= in.port_value;
        end
    end

endmodule

`default_nettype wire

FILE: src/mqc_back.sv
// ----------------------------------------------------------------------------
// mqc_back: encoder walker
// Pops a changed sample, marks the encoders it touches, then steps each marked
// one in index order into the output register, stalling while a result is held.
// ----------------------------------------------------------------------------
`default_nettype none

module mqc_back
    import mqc_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire cfg_t         cfg,
    input  wire logic         q_empty,
    input  wire sample_item_t q_item,
    output logic              q_pop,
    mqc_out_if.source         out
);

    back_state_t               state_reg;
    back_state_t               state_next;
    sample_item_t              item_reg;
    logic [MAX_ENCODERS-1:0]   mask_reg;
    logic [MAX_ENCODERS-1:0]   hit_mask;
    logic [ENC_IDX_W-1:0]      idx_reg;

    logic [1:0]                ab_reg    [MAX_ENCODERS];
    logic [COUNT_BITS-1:0]     count_reg [MAX_ENCODERS];
    logic signed [DIR_W-1:0]   dir_reg   [MAX_ENCODERS];

    logic                      out_valid_reg;
    logic [ENC_IDX_W-1:0]      out_index_reg;
    logic signed [POS_W-1:0]   out_pos_reg;
    logic signed [DIR_W-1:0]   out_dir_reg;
    logic                      out_final_reg;

    logic                      load;
    logic                      out_free;
    logic                      is_hit;
    logic                      is_last;
    logic                      step_en;
    logic                      emit;
    logic                      done;

    logic [PIN_W-1:0]          pin_a;
    logic [PIN_W-1:0]          pin_b;
    mode_t                     mode;
    logic                      a_now;
    logic                      b_now;
    logic [1:0]                ab_old;
    logic signed [DIR_W-1:0]   change;
    logic [COUNT_BITS-1:0]     count_new;
    logic signed [DIR_W-1:0]   dir_new;

    // Mark every in-use encoder on this port whose A or B pin changed
    always_comb
    begin
        for (int i = 0; i < MAX_ENCODERS; i++)
        begin
            hit_mask[i] = (ENC_COUNT_W'(i) < cfg.encoder_count)
                && (cfg.encoder_ports[PORT_W*i +: PORT_W] == q_item.port)
                && (q_item.diff[cfg.encoder_pin_a[PIN_W*i +: PIN_W]]
                    || q_item.diff[cfg.encoder_pin_b[PIN_W*i +: PIN_W]]);
        end
    end

    // Step decode of the encoder under the walk pointer
    always_comb
    begin
        pin_a  = cfg.encoder_pin_a[PIN_W*idx_reg +: PIN_W];
        pin_b  = cfg.encoder_pin_b[PIN_W*idx_reg +: PIN_W];
        mode   = mode_t'(cfg.encoder_modes[MODE_W*idx_reg +: MODE_W]);
        a_now  = item_reg.sample[pin_a];
        b_now  = item_reg.sample[pin_b];
        ab_old = ab_reg[idx_reg];
        change = DIR_NONE;
        unique case (mode)
            MODE_4X:
            begin
                change = step_lookup({ab_old, a_now, b_now});
            end
            MODE_2X:
            begin
                if (a_now != ab_old[1])
                begin
                    change = (a_now != ab_old[0]) ? DIR_FWD : DIR_BWD;
                end
            end
            MODE_1X, MODE_1X_ALT:
            begin
                if (!ab_old[1] && a_now)
                begin
                    change = b_now ? DIR_FWD : DIR_BWD;
                end
            end
        endcase

        count_new = count_reg[idx_reg];
        dir_new   = dir_reg[idx_reg];
        if (change == DIR_FWD)
        begin
            count_new = count_reg[idx_reg] + 1'b1;
            dir_new   = change;
        end
        else if (change == DIR_BWD)
        begin
            count_new = count_reg[idx_reg] - 1'b1;
            dir_new   = change;
        end
    end

    assign out_free = !out_valid_reg || out.ready;
    assign is_hit   = mask_reg[idx_reg];
    assign is_last  = ((mask_reg >> idx_reg) >> 1) == '0;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_IDLE:
            begin
                if (!q_empty && (hit_mask != '0))
                begin
                    state_next = BACK_WALK;
                end
            end
            BACK_WALK:
            begin
                if (done)
                begin
                    state_next = BACK_IDLE;
                end
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        q_pop   = 1'b0;
        load    = 1'b0;
        step_en = 1'b0;
        unique case (state_reg)
            BACK_IDLE:
            begin
                q_pop = !q_empty;
                load  = !q_empty && (hit_mask != '0);
            end
            BACK_WALK:
            begin
                step_en = !is_hit || out_free;
            end
        endcase
        emit = step_en && is_hit;
        done = emit && is_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BACK_IDLE;
            idx_reg       <= '0;
            mask_reg      <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_ENCODERS; i++)
            begin
                ab_reg[i]    <= '0;
                count_reg[i] <= '0;
                dir_reg[i]   <= DIR_NONE;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load)
            begin
                mask_reg <= hit_mask;
                idx_reg  <= '0;
            end
            else if (step_en && !done)
            begin
                idx_reg <= idx_reg + 1'b1;
            end

            if (emit)
            begin
                ab_reg[idx_reg]    <= {a_now, b_now};
                count_reg[idx_reg] <= count_new;
                dir_reg[idx_reg]   <= dir_new;
                out_valid_reg      <= 1'b1;
            end
            else if (out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= q_item;
        end
        if (emit)
        begin
            out_index_reg <= idx_reg;
            out_pos_reg   <= POS_W'(count_new);
            out_dir_reg   <= dir_new;
            out_final_reg <= is_last;
        end
    end

    assign out.valid          = out_valid_reg;
    assign out.encoder_index  = out_index_reg;
    assign out.position_count = out_pos_reg;
    assign out.last_direction = out_dir_reg;
    assign out.final_result   = out_final_reg;

endmodule

`default_nettype wire

FILE: verif/mqc_count_checker.sv
// ----------------------------------------------------------------------------
// mqc_count_checker: result predictor and comparator
// Watches the sample, result and register channels of the quadrature
// counter, keeps its own copy of every encoder's state and checks each
// result transaction, field by field, against the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module mqc_count_checker
    import mqc_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    mqc_in_if    sample_ch,
    mqc_out_if   result_ch,
    mqc_cfg_if   reg_ch,
    output int   fail_count,
    output int   pending_results
);

    typedef struct {
        logic [ENC_IDX_W-1:0]    encoder_index;
        logic signed [POS_W-1:0] position_count;
        logic signed [DIR_W-1:0] last_direction;
        logic                    final_result;
    } count_update_t;

    // step per {old A, old B, new A, new B}
    localparam int QUAD_STEP [16] = '{ 0, -1,  1,  0,
                                       1,  0,  0, -1,
                                      -1,  0,  0,  1,
                                       0,  1, -1,  0};

    cfg_t                    shadow_cfg;
    logic [SAMPLE_W-1:0]     last_sample [PORT_COUNT];
    logic [1:0]              last_ab     [MAX_ENCODERS];
    logic signed [POS_W-1:0] enc_count   [MAX_ENCODERS];
    logic signed [DIR_W-1:0] enc_dir     [MAX_ENCODERS];
    count_update_t           expected_updates [$];
    count_update_t           due;

    task automatic decode_sample(input logic [PORT_W-1:0] port,
                                 input logic [SAMPLE_W-1:0] value);
        logic [SAMPLE_W-1:0] changed;
        int                  active;
        logic [PORT_W-1:0]   enc_port;
        logic [PIN_W-1:0]    pin_a;
        logic [PIN_W-1:0]    pin_b;
        mode_t               mode;
        logic                a;
        logic                b;
        logic                old_a;
        logic                old_b;
        int                  step;
        count_update_t       held;
        logic                have_held;

        if (port >= PORT_COUNT)
            return;
        changed = value ^ last_sample[port];
        if (changed == '0)
            return;
        last_sample[port] = value;
        active = (shadow_cfg.encoder_count > MAX_ENCODERS) ? MAX_ENCODERS
                                                           : shadow_cfg.encoder_count;
        have_held = 1'b0;
        for (int i = 0; i < active; i++)
        begin
            enc_port = shadow_cfg.encoder_ports[MODE_W*i +: PORT_W];
            pin_a    = shadow_cfg.encoder_pin_a[PIN_W*i +: PIN_W];
            pin_b    = shadow_cfg.encoder_pin_b[PIN_W*i +: PIN_W];
            mode     = mode_t'(shadow_cfg.encoder_modes[MODE_W*i +: MODE_W]);
            if (enc_port != port)
                continue;
            if (!changed[pin_a] && !changed[pin_b])
                continue;
            a     = value[pin_a];
            b     = value[pin_b];
            old_a = last_ab[i][1];
            old_b = last_ab[i][0];
            step  = 0;
            case (mode)
                MODE_4X: step = QUAD_STEP[{old_a, old_b, a, b}];
                MODE_2X:
                begin
                    if (a != old_a)
                        step = (a != old_b) ? 1 : -1;
                end
                default:
                begin
                    if (!old_a && a)
                        step = b ? 1 : -1;
                end
            endcase
            if (step > 0)
            begin
                enc_count[i] = enc_count[i] + 32'sd1;
                enc_dir[i]   = DIR_FWD;
            end
            else if (step < 0)
            begin
                enc_count[i] = enc_count[i] - 32'sd1;
                enc_dir[i]   = DIR_BWD;
            end
            last_ab[i] = {a, b};
            // hold each update back one encoder so the last one can be flagged
            if (have_held)
                expected_updates.push_back(held);
            held.encoder_index  = ENC_IDX_W'(i);
            held.position_count = enc_count[i];
            held.last_direction = enc_dir[i];
            held.final_result   = 1'b0;
            have_held = 1'b1;
        end
        if (have_held)
        begin
            held.final_result = 1'b1;
            expected_updates.push_back(held);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shadow_cfg = '0;
            foreach (last_sample[p])
                last_sample[p] = '0;
            foreach (last_ab[e])
            begin
                last_ab[e]   = '0;
                enc_count[e] = '0;
                enc_dir[e]   = DIR_NONE;
            end
            expected_updates.delete();
            fail_count      = 0;
            pending_results = 0;
        end
        else
        begin
            // results in flight now come from earlier samples: compare first
            if (result_ch.valid && result_ch.ready)
            begin
                if (expected_updates.size() == 0)
                begin
                    $error("result for encoder %0d with no update pending",
                           result_ch.encoder_index);
                    fail_count++;
                end
                else
                begin
                    due = expected_updates.pop_front();
                    if (result_ch.encoder_index !== due.encoder_index)
                    begin
                        $error("encoder_index: expected %0d, got %0d",
                               due.encoder_index, result_ch.encoder_index);
                        fail_count++;
                    end
                    if (result_ch.position_count !== due.position_count)
                    begin
                        $error("position_count: expected %0d, got %0d",
                               due.position_count, result_ch.position_count);
                        fail_count++;
                    end
                    if (result_ch.last_direction !== due.last_direction)
                    begin
                        $error("last_direction: expected %0d, got %0d",
                               due.last_direction, result_ch.last_direction);
                        fail_count++;
                    end
                    if (result_ch.final_result !== due.final_result)
                    begin
                        $error("final_result: expected %0d, got %0d",
                               due.final_result, result_ch.final_result);
                        fail_count++;
                    end
                end
            end
            if (reg_ch.valid && reg_ch.ready)
            begin
                case (reg_index_t'(reg_ch.index))
                    REG_ENCODER_COUNT:
                        shadow_cfg.encoder_count = reg_ch.data[ENC_COUNT_W-1:0];
                    REG_ENCODER_PORTS:
                        shadow_cfg.encoder_ports = reg_ch.data[ENC_PORTS_W-1:0];
                    REG_ENCODER_PIN_A:
                        shadow_cfg.encoder_pin_a = reg_ch.data[ENC_PINS_W-1:0];
                    REG_ENCODER_PIN_B:
                        shadow_cfg.encoder_pin_b = reg_ch.data[ENC_PINS_W-1:0];
                    REG_ENCODER_MODES:
                        shadow_cfg.encoder_modes = reg_ch.data[ENC_MODES_W-1:0];
                    default: ;
                endcase
            end
            if (sample_ch.valid && sample_ch.ready)
                decode_sample(sample_ch.port_index, sample_ch.port_value);
            pending_results = expected_updates.size();
        end
    end

endmodule

FILE: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: quadrature counter testbench
// Programs several encoder layouts, drives directed and random port
// samples with random idling and a long result stall, and reports the
// verdict from the checker's failure count.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
    import mqc_pkg::*;

    localparam int PHASE_ITEMS     = 25;
    localparam int HOLD_OFF_CYCLES = 150;
    localparam int DRAIN_CYCLES    = 32;

    logic                clk;
    logic                rst_n;
    int                  sender_idle_pct;
    int                  receiver_idle_pct;
    logic                hold_off_req;
    int                  fail_count;
    int                  pending_results;
    cfg_t                plan;
    logic [SAMPLE_W-1:0] sent_sample [PORT_COUNT];

    mqc_in_if  in_ch ();
    mqc_out_if out_ch ();
    mqc_cfg_if cfg_ch ();

    multi_quadrature_counter DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .in    (in_ch),
        .out   (out_ch),
        .cfg   (cfg_ch)
    );

    mqc_count_checker u_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample_ch       (in_ch),
        .result_ch       (out_ch),
        .reg_ch          (cfg_ch),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    initial
    begin
        #2000000;
        $display("Some tests failed");
        $finish;
    end

    // result side: random ready, with a long hold-off on request
    initial
    begin : receiver
        int stall_left;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                stall_left   = HOLD_OFF_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
                out_ch.ready <= rst_n && ($urandom_range(99) >= receiver_idle_pct);
        end
    end

    task automatic send_sample(input logic [PORT_W-1:0] port,
                               input logic [SAMPLE_W-1:0] value);
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.port_index <= port;
        in_ch.port_value <= value;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (port < PORT_COUNT)
            sent_sample[port] = value;
    endtask

    task automatic write_reg(input reg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic apply_plan();
        write_reg(REG_ENCODER_COUNT, CFG_DATA_W'(plan.encoder_count));
        write_reg(REG_ENCODER_PORTS, CFG_DATA_W'(plan.encoder_ports));
        write_reg(REG_ENCODER_PIN_A, CFG_DATA_W'(plan.encoder_pin_a));
        write_reg(REG_ENCODER_PIN_B, CFG_DATA_W'(plan.encoder_pin_b));
        write_reg(REG_ENCODER_MODES, CFG_DATA_W'(plan.encoder_modes));
    endtask

    function automatic void set_encoder(input int idx, input logic [PORT_W-1:0] port,
                                        input logic [PIN_W-1:0] pin_a,
                                        input logic [PIN_W-1:0] pin_b, input mode_t mode);
        plan.encoder_ports[MODE_W*idx +: PORT_W] = port;
        plan.encoder_pin_a[PIN_W*idx +: PIN_W]   = pin_a;
        plan.encoder_pin_b[PIN_W*idx +: PIN_W]   = pin_b;
        plan.encoder_modes[MODE_W*idx +: MODE_W] = mode;
    endfunction

    // lower valid, wait out every pending result and the walker's tail
    task automatic drain();
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // mostly single-pin steps on a watched pin, plus noise and ignored samples
    task automatic random_traffic(input int items);
        int                  done;
        int                  pick;
        int                  enc;
        logic [PORT_W-1:0]   port;
        logic [PIN_W-1:0]    bit_pos;
        logic [SAMPLE_W-1:0] value;

        done = 0;
        while (done < items)
        begin
            pick = $urandom_range(99);
            port = PORT_W'($urandom_range(PORT_COUNT - 1));
            if (pick < 65)
            begin
                enc = $urandom_range(MAX_ENCODERS - 1);
                if (plan.encoder_ports[MODE_W*enc +: PORT_W] < PORT_COUNT)
                    port = plan.encoder_ports[MODE_W*enc +: PORT_W];
                bit_pos = $urandom_range(1) ? plan.encoder_pin_a[PIN_W*enc +: PIN_W]
                                            : plan.encoder_pin_b[PIN_W*enc +: PIN_W];
                value = sent_sample[port] ^ (SAMPLE_W'(1) << bit_pos);
            end
            else if (pick < 85)
                value = SAMPLE_W'($urandom);
            else if (pick < 92)
            begin
                value = sent_sample[port];
            end
            else
            begin
                value = SAMPLE_W'($urandom);
                port  = PORT_W'($urandom_range(2**PORT_W - 1, PORT_COUNT));
            end
            if (port < PORT_COUNT && value != sent_sample[port])
                done++;
            send_sample(port, value);
        end
    endtask

    initial
    begin
        rst_n             = 1'b0;
        hold_off_req      = 1'b0;
        sender_idle_pct   = 6;
        receiver_idle_pct = 82;
        in_ch.valid       = 1'b0;
        in_ch.port_index  = '0;
        in_ch.port_value  = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = REG_ENCODER_COUNT;
        cfg_ch.data       = '0;
        plan              = '0;
        foreach (sent_sample[p])
            sent_sample[p] = '0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // layout with every mode, a shared A/B pin and an encoder on no port
        plan.encoder_count = 4'd8;
        set_encoder(0, 2'd0, 3'd0, 3'd1, MODE_4X);
        set_encoder(1, 2'd0, 3'd2, 3'd3, MODE_2X);
        set_encoder(2, 2'd0, 3'd4, 3'd5, MODE_1X);
        set_encoder(3, 2'd1, 3'd0, 3'd1, MODE_1X_ALT);
        set_encoder(4, 2'd1, 3'd6, 3'd6, MODE_4X);
        set_encoder(5, 2'd2, 3'd7, 3'd0, MODE_4X);
        set_encoder(6, 2'd2, 3'd1, 3'd2, MODE_2X);
        set_encoder(7, PORT_W'(PORT_COUNT), 3'd0, 3'd1, MODE_4X);
        apply_plan();

        send_sample(PORT_W'(PORT_COUNT), 8'hFF);
        send_sample(2'd0, 8'h00);
        // one full quadrature cycle each way on port 0
        send_sample(2'd0, 8'h02);
        send_sample(2'd0, 8'h03);
        send_sample(2'd0, 8'h01);
        send_sample(2'd0, 8'h00);
        send_sample(2'd0, 8'h01);
        send_sample(2'd0, 8'h03);
        send_sample(2'd0, 8'h02);
        send_sample(2'd0, 8'h00);
        send_sample(2'd0, 8'hFF);
        send_sample(2'd0, 8'h00);
        send_sample(2'd0, 8'h55);
        send_sample(2'd0, 8'hAA);
        send_sample(2'd1, 8'h01);
        send_sample(2'd1, 8'h03);
        send_sample(2'd1, 8'h40);
        send_sample(2'd1, 8'hFF);
        send_sample(2'd1, 8'h00);
        send_sample(2'd2, 8'h80);
        send_sample(2'd2, 8'h81);
        send_sample(2'd2, 8'h06);
        send_sample(2'd2, 8'hFF);
        send_sample(2'd2, 8'hFF);
        send_sample(2'd2, 8'h00);

        // stall the result side long enough to back up the input
        hold_off_req = 1'b1;
        random_traffic(PHASE_ITEMS);
        drain();

        sender_idle_pct    = 82;
        receiver_idle_pct  = 6;
        plan.encoder_count = ENC_COUNT_W'($urandom_range(MAX_ENCODERS, 1));
        for (int i = 0; i < MAX_ENCODERS; i++)
            set_encoder(i, PORT_W'($urandom_range(2**PORT_W - 1)), PIN_W'($urandom),
                        PIN_W'($urandom), mode_t'($urandom_range(3)));
        apply_plan();
        random_traffic(PHASE_ITEMS);
        drain();

        // oversized count, all encoders on port 0, outermost pins
        sender_idle_pct    = 0;
        receiver_idle_pct  = 0;
        plan.encoder_count = '1;
        plan.encoder_ports = '0;
        plan.encoder_pin_a = '1;
        plan.encoder_pin_b = '0;
        plan.encoder_modes = '1;
        apply_plan();
        random_traffic(PHASE_ITEMS);
        drain();

        // nothing in use: samples are stored but produce no results
        plan.encoder_count = '0;
        plan.encoder_ports = '1;
        plan.encoder_pin_a = '0;
        plan.encoder_pin_b = '1;
        plan.encoder_modes = '0;
        apply_plan();
        random_traffic(8);
        drain();

        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
